FILE: rtl/tcwv_pkg.sv
// ----------------------------------------------------------------------------
// tcwv_pkg
// Shared widths, codes and lane control types for the two-channel Welford
// variance block.
// ----------------------------------------------------------------------------
package tcwv_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = 40;
  localparam int DEV_W       = 64;
  localparam int CNT_W       = 16;
  localparam int DVS_W       = CNT_W + 1;
  localparam int DIV_W       = 64;
  localparam int STD_W       = 16;
  localparam int VAR_W       = 32;
  localparam int ROOT_W      = STD_W + 2;
  localparam int REM_W       = 34;
  localparam int SQRT_STEPS  = 16;
  localparam int ADDR_W      = 2;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = 16'd250;
  localparam logic [CNT_W-1:0] COUNT_MIN   = 16'd2;
  localparam logic [ADDR_W-1:0] REG_SAMPLE_COUNT = 2'd0;

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIV_MEAN,
    L_MUL,
    L_ACC,
    L_DIV_VAR,
    L_DIV_AVG,
    L_SQRT,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic             start;
    logic             seed;
    logic             last;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean;
    logic signed [SAMPLE_BITS-1:0] avg;
    logic        [STD_W-1:0]       std;
  } lane_res_t;

endpackage

FILE: rtl/tcwv_in_if.sv
// ----------------------------------------------------------------------------
// tcwv_in_if
// Input channel: one record of two signed samples per transfer.
// ----------------------------------------------------------------------------
interface tcwv_in_if;
  import tcwv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] first_sample;
  logic signed [SAMPLE_BITS-1:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface

FILE: rtl/tcwv_out_if.sv
// ----------------------------------------------------------------------------
// tcwv_out_if
// Result channel: per-channel means and standard deviation per transfer.
// ----------------------------------------------------------------------------
interface tcwv_out_if;
  import tcwv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] first_running_mean;
  logic signed [SAMPLE_BITS-1:0] first_sum_mean;
  logic        [STD_W-1:0]       first_std_dev;
  logic signed [SAMPLE_BITS-1:0] second_running_mean;
  logic signed [SAMPLE_BITS-1:0] second_sum_mean;
  logic        [STD_W-1:0]       second_std_dev;

  modport source (output valid, output first_running_mean, output first_sum_mean,
                  output first_std_dev, output second_running_mean,
                  output second_sum_mean, output second_std_dev, input ready);
  modport sink (input valid, input first_running_mean, input first_sum_mean,
                input first_std_dev, input second_running_mean,
                input second_sum_mean, input second_std_dev, output ready);
endinterface

FILE: rtl/tcwv_div.sv
// ----------------------------------------------------------------------------
// tcwv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcwv_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tcwv_pkg::DIV_W-1:0] dividend,
  input  logic [tcwv_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [tcwv_pkg::DIV_W-1:0] quotient
);
  import tcwv_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

  logic [DIV_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, q_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

FILE: rtl/tcwv_lane.sv
// ----------------------------------------------------------------------------
// tcwv_lane
// One channel: Welford update per sample, end-of-run divisions and root.
// ----------------------------------------------------------------------------
module tcwv_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tcwv_pkg::lane_cmd_t                  cmd,
  input  logic signed [tcwv_pkg::SAMPLE_BITS-1:0] x,
  output tcwv_pkg::lane_stat_t                 stat,
  output tcwv_pkg::lane_res_t                  res
);
  import tcwv_pkg::*;

  lane_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] mean_r;
  logic signed [SAMPLE_BITS-1:0] avg_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic        [DEV_W-1:0]       dev_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic        [CNT_W-1:0]       cnt_r;
  logic                          last_r;
  logic        [VAR_W-1:0]       var_r;
  logic        [VAR_W-1:0]       a_r;
  logic        [ROOT_W-1:0]      root_r;
  logic        [REM_W-1:0]       rem_r;
  logic        [3:0]             step_r;

  logic                          div_start;
  logic        [DIV_W-1:0]       div_dvd;
  logic        [DVS_W-1:0]       div_dvs;
  logic                          div_done;
  logic        [DIV_W-1:0]       div_q;

  logic signed [DIFF_W-1:0]      diff_in;
  logic        [DIFF_W-1:0]      diff_abs;
  logic        [DEV_W-1:0]       dev_nxt;
  logic        [SUM_W-1:0]       sum_abs;
  logic signed [SUM_W-1:0]       x_ext;
  logic signed [DIFF_W-1:0]      q_mag;
  logic signed [DIFF_W-1:0]      q_sgn;
  logic signed [DIFF_W-1:0]      mean_new;
  logic        [ROOT_W-1:0]      root_t;
  logic        [REM_W-1:0]       rem_t;

  assign x_ext    = {{(SUM_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  assign diff_in  = {x[SAMPLE_BITS-1], x} - {mean_r[SAMPLE_BITS-1], mean_r};
  assign diff_abs = diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : diff_in;
  assign dev_nxt  = prod_r[PROD_W-1] ? dev_r : dev_r + DEV_W'(prod_r);
  assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;
  assign q_mag    = div_q[DIFF_W-1:0];
  assign q_sgn    = diff_r[DIFF_W-1] ? -q_mag : q_mag;
  assign mean_new = {mean_r[SAMPLE_BITS-1], mean_r} + q_sgn;
  assign root_t   = {root_r[ROOT_W-2:0], 1'b0};
  assign rem_t    = {rem_r[REM_W-3:0], a_r[VAR_W-1:VAR_W-2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_r)
      L_IDLE: begin
        if (cmd.start && !cmd.seed) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(diff_abs);
          div_dvs   = DVS_W'(cmd.idx) + 1'b1;
          state_nxt = L_DIV_MEAN;
        end
      end
      L_DIV_MEAN: begin
        if (div_done) begin
          state_nxt = L_MUL;
        end
      end
      L_MUL: state_nxt = L_ACC;
      L_ACC: begin
        if (last_r) begin
          div_start = 1'b1;
          div_dvd   = dev_nxt;
          div_dvs   = DVS_W'(cnt_r) - 1'b1;
          state_nxt = L_DIV_VAR;
        end else begin
          state_nxt = L_IDLE;
        end
      end
      L_DIV_VAR: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(sum_abs);
          div_dvs   = DVS_W'(cnt_r);
          state_nxt = L_DIV_AVG;
        end
      end
      L_DIV_AVG: begin
        if (div_done) begin
          state_nxt = L_SQRT;
        end
      end
      L_SQRT: begin
        if (step_r == 4'(SQRT_STEPS - 1)) begin
          state_nxt = L_DONE;
        end
      end
      L_DONE: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          x_r    <= x;
          diff_r <= diff_in;
          last_r <= cmd.last;
          cnt_r  <= cmd.count;
          if (cmd.seed) begin
            mean_r <= x;
            dev_r  <= '0;
            sum_r  <= x_ext;
          end else begin
            sum_r  <= sum_r + x_ext;
          end
        end
      end
      L_DIV_MEAN: begin
        if (div_done) begin
          mean_r <= mean_new[SAMPLE_BITS-1:0];
        end
      end
      L_MUL: begin
        prod_r <= diff_r * $signed({x_r[SAMPLE_BITS-1], x_r} - {mean_r[SAMPLE_BITS-1], mean_r});
      end
      L_ACC: dev_r <= dev_nxt;
      L_DIV_VAR: begin
        if (div_done) begin
          var_r <= (|div_q[DIV_W-1:VAR_W]) ? '1 : div_q[VAR_W-1:0];
        end
      end
      L_DIV_AVG: begin
        if (div_done) begin
          avg_r  <= sum_r[SUM_W-1] ? -div_q[SAMPLE_BITS-1:0] : div_q[SAMPLE_BITS-1:0];
          a_r    <= var_r;
          root_r <= '0;
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      L_SQRT: begin
        a_r    <= {a_r[VAR_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
        if (REM_W'(root_t) < rem_t) begin
          rem_r  <= rem_t - REM_W'(root_t) - 1'b1;
          root_r <= root_t + 2'd2;
        end else begin
          rem_r  <= rem_t;
          root_r <= root_t;
        end
      end
      default: begin
      end
    endcase
  end

  tcwv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.busy = (state_r != L_IDLE);
  assign stat.done = (state_r == L_DONE);
  assign res.mean  = mean_r;
  assign res.avg   = avg_r;
  assign res.std   = root_r[STD_W:1];
endmodule

FILE: rtl/tcwv_merge.sv
// ----------------------------------------------------------------------------
// tcwv_merge
// Collect lane results into the output register and hold until transfer.
// ----------------------------------------------------------------------------
module tcwv_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcwv_pkg::lane_stat_t stat [tcwv_pkg::CHANNELS],
  input  tcwv_pkg::lane_res_t  res  [tcwv_pkg::CHANNELS],
  tcwv_out_if.source           out_ch
);
  import tcwv_pkg::*;

  logic                valid_r;
  lane_res_t           res_r [CHANNELS];
  logic [CHANNELS-1:0] done_vec;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      done_vec[i] = stat[i].done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (&done_vec) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (&done_vec) begin
      for (int i = 0; i < CHANNELS; i++) begin
        res_r[i] <= res[i];
      end
    end
  end

  assign out_ch.valid               = valid_r;
  assign out_ch.first_running_mean  = res_r[0].mean;
  assign out_ch.first_sum_mean      = res_r[0].avg;
  assign out_ch.first_std_dev       = res_r[0].std;
  assign out_ch.second_running_mean = res_r[1].mean;
  assign out_ch.second_sum_mean     = res_r[1].avg;
  assign out_ch.second_std_dev      = res_r[1].std;
endmodule

FILE: rtl/two_channel_welford_variance.sv
// ----------------------------------------------------------------------------
// two_channel_welford_variance
// Per-channel Welford mean, plain mean and standard deviation over runs of
// sample_count records.
// ----------------------------------------------------------------------------
//   channel | direction | contents
//   in_ch   | in        | first_sample, second_sample
//   out_ch  | out       | running mean, sum mean, std dev per channel
//   apb     | in/out    | sample_count at address 0
//
// A seeding record only loads the lane registers; a later record runs the
// 64-step divider for the mean update, then multiply and accumulate. The last
// record of a run adds the variance and sum-mean divisions and the square root.
// Synchronous active-low reset; no clearing pass.
// A pending result stalls only the record that would end the next run.
// ----------------------------------------------------------------------------
module two_channel_welford_variance (
  input  logic                         clk,
  input  logic                         rst_n,
  tcwv_in_if.sink                      in_ch,
  tcwv_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcwv_pkg::ADDR_W-1:0]  paddr,
  input  logic [tcwv_pkg::DATA_W-1:0]  pwdata,
  output logic [tcwv_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import tcwv_pkg::*;

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              idx_r;
  logic [CNT_W-1:0]              cnt_eff;
  logic                          is_last;
  logic                          lanes_idle;
  logic                          xfer;
  lane_cmd_t                     cmd;
  lane_stat_t                    stat [CHANNELS];
  lane_res_t                     res  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] samples [CHANNELS];

  assign pready  = 1'b1;
  assign prdata  = (paddr == REG_SAMPLE_COUNT) ? DATA_W'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_SAMPLE_COUNT) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign cnt_eff = (count_r < COUNT_MIN) ? COUNT_MIN : count_r;
  assign is_last = ({1'b0, idx_r} + 1'b1) >= {1'b0, cnt_eff};

  always_comb begin
    lanes_idle = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      lanes_idle = lanes_idle && !stat[i].busy;
    end
  end

  assign in_ch.ready = lanes_idle && !(out_ch.valid && is_last);
  assign xfer        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (xfer) begin
      idx_r <= is_last ? '0 : idx_r + 1'b1;
    end
  end

  assign cmd.start = xfer;
  assign cmd.seed  = (idx_r == '0);
  assign cmd.last  = is_last;
  assign cmd.idx   = idx_r;
  assign cmd.count = cnt_eff;

  assign samples[0] = in_ch.first_sample;
  assign samples[1] = in_ch.second_sample;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    tcwv_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .x     (samples[g]),
      .stat  (stat[g]),
      .res   (res[g])
    );
  end

  tcwv_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat   (stat),
    .res    (res),
    .out_ch (out_ch)
  );
endmodule

FILE: rtl/tcwv_checker.sv
// ----------------------------------------------------------------------------
// tcwv_checker
// Port-level checks on the result channel and the register port.
// ----------------------------------------------------------------------------
module tcwv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_mean,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import tcwv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mean))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr == REG_SAMPLE_COUNT &&
    $past(paddr) == REG_SAMPLE_COUNT ##1 paddr == REG_SAMPLE_COUNT
    |-> prdata[15:0] == $past(pwdata[15:0]) && prdata[31:16] == 16'd0)
    else $error("sample_count readback mismatch");

endmodule

bind two_channel_welford_variance tcwv_checker u_tcwv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mean  (out_ch.first_running_mean),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
